@@ design/sem_pkg.sv @@
// Shared types and constants for the Sobel edge magnitude stream block.
`default_nettype none
package sem_pkg;

   localparam logic [1:0] MODE_X    = 2'd0;
   localparam logic [1:0] MODE_Y    = 2'd1;
   localparam logic [1:0] MODE_SUM  = 2'd2;
   localparam logic [1:0] MODE_COPY = 2'd3;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [1:0]  MODE_RESET   = MODE_SUM;
   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [11:0] HEIGHT_RESET = 12'd480;

   localparam int CSR_DW = 12;

   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [7:0] PIX_MAX = 8'd255;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } sem_req_type;

   typedef struct packed {
      logic [11:0] out_row;
      logic [9:0]  out_col;
      logic [7:0]  out_value;
      logic        last;
   } sem_rsp_type;

   typedef struct packed {
      logic [7:0] upper;
      logic [7:0] middle;
   } sem_column_type;

   typedef struct packed {
      logic [7:0]  pixel;
      logic [11:0] row;
      logic [9:0]  col;
      logic        center;
      logic        border;
   } sem_tag_type;

   typedef struct packed {
      logic [1:0]  num;
      sem_rsp_type first;
      sem_rsp_type second;
   } sem_push_type;

endpackage
`default_nettype wire

@@ design/sem_stream_if.sv @@
// Valid/ready stream channel carrying one word per handshake.
`default_nettype none
interface sem_stream_if #(
   parameter type word_type = logic [7:0]
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

@@ design/sem_line_store.sv @@
// Two-row line store: one column word per address, registered read.
`default_nettype none
module sem_line_store
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output sem_column_type                    rd_data,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  wire sem_column_type               wr_data
);

   sem_column_type mem [MAX_WIDTH];
   sem_column_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ design/sem_edge_unit.sv @@
// 3x3 window and Sobel gradient stage; builds up to two result words per pixel.
`default_nettype none
module sem_edge_unit
   import sem_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire sem_tag_type    in_tag,
   input  wire sem_column_type in_column,
   input  wire logic [1:0]     mode,
   output sem_push_type        push
);

   logic [7:0]  win_ff [3][3];
   logic [7:0]  win_in [3][3];
   logic        s2_valid_ff;
   sem_tag_type s2_tag_ff;

   logic [9:0]  left_sum, right_sum, top_sum, bot_sum;
   logic [9:0]  abs_x, abs_y;
   logic [10:0] sel;
   logic [7:0]  value;
   sem_rsp_type center_word, border_word;

   always_comb begin
      win_in = win_ff;
      if (in_valid) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[0][2] = in_column.upper;
         win_in[1][2] = in_column.middle;
         win_in[2][2] = in_tag.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= 8'd0;
            end
         end
      end else begin
         s2_valid_ff <= in_valid;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s2_tag_ff <= in_tag;
      end
   end

   // weights 1,2,1 along each edge of the window
   always_comb begin
      left_sum  = {2'b0, win_ff[0][0]} + {1'b0, win_ff[1][0], 1'b0} + {2'b0, win_ff[2][0]};
      right_sum = {2'b0, win_ff[0][2]} + {1'b0, win_ff[1][2], 1'b0} + {2'b0, win_ff[2][2]};
      top_sum   = {2'b0, win_ff[0][0]} + {1'b0, win_ff[0][1], 1'b0} + {2'b0, win_ff[0][2]};
      bot_sum   = {2'b0, win_ff[2][0]} + {1'b0, win_ff[2][1], 1'b0} + {2'b0, win_ff[2][2]};
      abs_x = (left_sum >= right_sum) ? left_sum - right_sum : right_sum - left_sum;
      abs_y = (top_sum >= bot_sum) ? top_sum - bot_sum : bot_sum - top_sum;
      case (mode)
         MODE_X:   sel = {1'b0, abs_x};
         MODE_Y:   sel = {1'b0, abs_y};
         MODE_SUM: sel = {1'b0, abs_x} + {1'b0, abs_y};
         default:  sel = {3'b0, win_ff[1][1]};
      endcase
      value = (sel > {3'b0, PIX_MAX}) ? PIX_MAX : sel[7:0];
   end

   always_comb begin
      center_word.out_row   = s2_tag_ff.row - 12'd1;
      center_word.out_col   = s2_tag_ff.col - 10'd1;
      center_word.out_value = value;
      center_word.last      = ~s2_tag_ff.border;
      border_word.out_row   = s2_tag_ff.row;
      border_word.out_col   = s2_tag_ff.col;
      border_word.out_value = s2_tag_ff.pixel;
      border_word.last      = 1'b1;

      push.first  = s2_tag_ff.center ? center_word : border_word;
      push.second = border_word;
      if (!s2_valid_ff) begin
         push.num = 2'd0;
      end else begin
         push.num = 2'({1'b0, s2_tag_ff.center} + {1'b0, s2_tag_ff.border});
      end
   end

endmodule
`default_nettype wire

@@ design/sem_result_fifo.sv @@
// Result queue: takes up to two words per cycle, gives one.
`default_nettype none
module sem_result_fifo
   import sem_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire sem_push_type   push,
   input  wire logic           pop,
   output sem_rsp_type         head,
   output logic                not_empty,
   output logic [FIFO_AW:0]    count
);

   sem_rsp_type        fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_nx = wr_ptr_ff + FIFO_AW'(1);
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.num);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW + 1)'(push.num) - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         fifo_ff[wr_ptr_nx] <= push.second;
      end
   end

   assign head      = fifo_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule
`default_nettype wire

@@ design/sobel_edge_magnitude_stream_top.sv @@
// Top level of the streaming 3x3 Sobel edge magnitude block.
`default_nettype none
// Takes one gray pixel per clock in raster order while ready is high and gives one
// word per pixel of the frame, tagged with row and column: interior pixels as Sobel
// magnitude (|gx|, |gy| or their sum, clamped to 255, or the pixel itself in copy
// mode), border pixels unchanged. A word passes stage 1, the window registers and
// the result queue before it is offered at the output. From the third row on, the
// pixel at the right edge of a row yields two words, as does each pixel of the last
// row from the third column on, while most pixels of the second row and of the
// second column yield none. A 16-word result queue evens this out, and the input
// holds ready low only while the queue could not take the words still in flight.
// Along a long last row the output drains at most one word per clock, so the input
// is then held back; elsewhere the rate is one pixel per clock while the output is
// not stalled, set by the line store with one read and one write of a column per
// clock. No clearing pass is run after reset. The user must write registers only
// while the block is idle; the block itself does not enforce this.
module sobel_edge_magnitude_stream_top
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   sem_stream_if.sink             req_bus,
   sem_stream_if.source           rsp_bus,
   input  wire logic              csr_write_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_DW-1:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;
   localparam int XW = (CW > 10) ? CW : 10;
   localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

   logic [1:0]  mode_ff;
   logic [10:0] width_ff;
   logic [11:0] height_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [11:0]   row_ff, row_in;

   logic          accept;
   sem_req_type   req_word;
   logic [CW-1:0] c;
   logic [11:0]   r;
   logic [WW-1:0] width_x, w_eff, c_x1;
   logic [11:0]   h_eff;
   logic [12:0]   r1;
   logic [XW-1:0] c_x;
   logic          last_col, last_row, center, border;
   sem_tag_type   tag;

   logic           s1_valid_ff;
   sem_tag_type    s1_tag_ff;
   logic [CW-1:0]  s1_addr_ff;
   logic           s1_fwd_ff;
   sem_column_type s1_fwd_data_ff;
   sem_column_type rd_data, col_eff, wr_data;

   sem_push_type       push;
   logic [FIFO_AW:0]   fifo_count;
   logic               fifo_not_empty;
   logic [FIFO_AW+1:0] reserve;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MODE:   mode_ff   <= csr_data[1:0];
            REG_WIDTH:  width_ff  <= csr_data[10:0];
            REG_HEIGHT: height_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   assign req_word = req_bus.word;
   assign accept   = req_bus.valid && req_bus.ready;

   // position of the arriving pixel and what it emits
   always_comb begin
      c       = req_word.frame_start ? '0 : col_ff;
      r       = req_word.frame_start ? '0 : row_ff;
      width_x = WW'(width_ff);
      if (width_x == '0) begin
         w_eff = WW'(1);
      end else if (width_x > MAXW) begin
         w_eff = MAXW;
      end else begin
         w_eff = width_x;
      end
      h_eff    = (height_ff == '0) ? 12'd1 : height_ff;
      c_x1     = WW'(c) + WW'(1);
      r1       = {1'b0, r} + 13'd1;
      last_col = (c_x1 >= w_eff);
      last_row = (r1 >= {1'b0, h_eff});
      center   = (r >= 12'd2) && (c >= CW'(2)) && (r1 <= {1'b0, h_eff}) && (c_x1 <= w_eff);
      border   = (r == '0) || (c == '0) || last_col || last_row;
      c_x      = XW'(c);

      tag.pixel  = req_word.pixel;
      tag.row    = r;
      tag.col    = c_x[9:0];
      tag.center = center;
      tag.border = border;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? 12'd0 : r1[11:0];
         end else begin
            col_in = CW'(c_x1);
            row_in = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   // stage 1: line store read; forward the column written in the same cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff      <= tag;
         s1_addr_ff     <= c;
         s1_fwd_ff      <= s1_valid_ff && (s1_addr_ff == c);
         s1_fwd_data_ff <= wr_data;
      end
   end

   assign col_eff        = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
   assign wr_data.upper  = col_eff.middle;
   assign wr_data.middle = s1_tag_ff.pixel;

   sem_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c),
      .rd_data (rd_data),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data)
   );

   sem_edge_unit u_edge_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_tag    (s1_tag_ff),
      .in_column (col_eff),
      .mode      (mode_ff),
      .push      (push)
   );

   sem_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_bus.valid && rsp_bus.ready),
      .head      (rsp_bus.word),
      .not_empty (fifo_not_empty),
      .count     (fifo_count)
   );

   assign rsp_bus.valid = fifo_not_empty;

   // room for the words of stage 1, stage 2 and a new pixel, two each at most
   always_comb begin
      reserve = (FIFO_AW + 2)'(fifo_count) + (FIFO_AW + 2)'(push.num)
              + (s1_valid_ff ? (FIFO_AW + 2)'(2) : '0) + (FIFO_AW + 2)'(2);
   end

   assign req_bus.ready = (reserve <= (FIFO_AW + 2)'(FIFO_DEPTH));

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ((FIFO_AW + 2)'(fifo_count) + (FIFO_AW + 2)'(push.num)) <= (FIFO_AW + 2)'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.frame_start) |=> (s1_tag_ff.row == '0 && s1_tag_ff.col == '0))
      else $error("frame start not at origin");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      int'(col_ff) < MAX_WIDTH)
      else $error("column counter out of range");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (push.num == 2'd2) |-> (!push.first.last && push.second.last))
      else $error("bad last flag on word pair");
`endif

endmodule
`default_nettype wire

@@ test/sobel_edge_magnitude_stream_top_tb.sv @@
// Testbench for sobel_edge_magnitude_stream_top: random frames checked against a Sobel predictor.
import sem_pkg::*;

class edge_scoreboard #(parameter int LINE_DEPTH = 1024);
   sem_rsp_type expected_words[$];
   logic [7:0]  upper_line [LINE_DEPTH];
   logic [7:0]  middle_line [LINE_DEPTH];
   logic [7:0]  win [3][3];
   int unsigned row_pos;
   int unsigned col_pos;
   logic [1:0]  mode_cfg;
   logic [10:0] width_cfg;
   logic [11:0] height_cfg;
   int          mismatch_count;
   int          words_checked;

   function void reset_state();
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      row_pos        = 0;
      col_pos        = 0;
      mode_cfg       = MODE_RESET;
      width_cfg      = WIDTH_RESET;
      height_cfg     = HEIGHT_RESET;
      mismatch_count = 0;
      words_checked  = 0;
      expected_words.delete();
   endfunction

   function void write_reg(logic [1:0] index, logic [CSR_DW-1:0] data);
      case (index)
         REG_MODE:   mode_cfg   = data[1:0];
         REG_WIDTH:  width_cfg  = data[10:0];
         REG_HEIGHT: height_cfg = data[11:0];
         default: ;
      endcase
   endfunction

   function logic [7:0] gradient_value();
      int gx, gy, s;
      gx = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0])
         - int'(win[0][2]) - 2 * int'(win[1][2]) - int'(win[2][2]);
      gy = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
         - int'(win[2][0]) - 2 * int'(win[2][1]) - int'(win[2][2]);
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      case (mode_cfg)
         MODE_X:   s = gx;
         MODE_Y:   s = gy;
         MODE_SUM: s = gx + gy;
         default:  s = int'(win[1][1]);
      endcase
      if (s > int'(PIX_MAX)) s = int'(PIX_MAX);
      return s[7:0];
   endfunction

   function void note_pixel(sem_req_type w);
      int unsigned wd, ht, r, c, idx;
      int          n;
      bit          at_last_col, at_last_row;
      sem_rsp_type outs [2];
      wd = (width_cfg == 0) ? 1 : width_cfg;
      if (wd > LINE_DEPTH) wd = LINE_DEPTH;
      ht = (height_cfg == 0) ? 1 : height_cfg;
      if (w.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      r   = row_pos;
      c   = col_pos;
      idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2]        = upper_line[idx];
      win[1][2]        = middle_line[idx];
      win[2][2]        = w.pixel;
      upper_line[idx]  = middle_line[idx];
      middle_line[idx] = w.pixel;
      at_last_col = (c >= wd - 1);
      at_last_row = (r >= ht - 1);
      n = 0;
      if (r >= 2 && c >= 2 && r <= ht - 1 && c <= wd - 1) begin
         outs[n] = '{out_row: 12'(r - 1), out_col: 10'(c - 1),
                     out_value: gradient_value(), last: 1'b0};
         n++;
      end
      if (r == 0 || c == 0 || at_last_col || at_last_row) begin
         outs[n] = '{out_row: 12'(r), out_col: 10'(c), out_value: w.pixel, last: 1'b0};
         n++;
      end
      if (n > 0) outs[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_words.push_back(outs[i]);
      if (at_last_col) begin
         col_pos = 0;
         row_pos = at_last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function void check_word(sem_rsp_type got);
      sem_rsp_type want;
      if (expected_words.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected word: row %0d col %0d value %0d last %0d",
                     got.out_row, got.out_col, got.out_value, got.last);
         return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
          got.out_value !== want.out_value || got.last !== want.last) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display({"mismatch: expected row %0d col %0d value %0d last %0d, ",
                      "got row %0d col %0d value %0d last %0d"},
                     want.out_row, want.out_col, want.out_value, want.last,
                     got.out_row, got.out_col, got.out_value, got.last);
      end
   endfunction

   function int pending();
      return expected_words.size();
   endfunction

   function void flag_leftovers();
      if (expected_words.size() != 0) begin
         $display("%0d expected words never arrived", expected_words.size());
         mismatch_count += expected_words.size();
      end
   endfunction
endclass

module sobel_edge_magnitude_stream_top_tb;

   localparam int LINE_DEPTH   = 1024;
   localparam int RANDOM_ITEMS = 1950;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 8;
   localparam logic [1:0] REG_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [1:0] csr_index;
   logic [CSR_DW-1:0] csr_data;

   sem_stream_if #(.word_type(sem_req_type)) req_bus ();
   sem_stream_if #(.word_type(sem_rsp_type)) rsp_bus ();

   sobel_edge_magnitude_stream_top #(.MAX_WIDTH(LINE_DEPTH)) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   edge_scoreboard #(LINE_DEPTH) sb;

   bit quiet;
   bit hold_request;
   int send_idle_pct;
   int recv_idle_pct;
   int pixels_sent;
   int phase_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_pixel(input logic [7:0] pix, input logic fs);
      int gap;
      sem_req_type w;
      w.pixel       = pix;
      w.frame_start = fs;
      if (!quiet && $urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.word  <= w;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_pixel(w);
      pixels_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] mode_v, input logic [10:0] width_v,
                             input logic [11:0] height_v);
      logic [CSR_DW-1:0] data_v;
      data_v = {10'($urandom), mode_v};
      csr_write_en <= 1'b1;
      csr_index    <= REG_MODE;
      csr_data     <= data_v;
      sb.write_reg(REG_MODE, data_v);
      @(posedge clock);
      data_v = {1'($urandom), width_v};
      csr_index <= REG_WIDTH;
      csr_data  <= data_v;
      sb.write_reg(REG_WIDTH, data_v);
      @(posedge clock);
      data_v = height_v;
      csr_index <= REG_HEIGHT;
      csr_data  <= data_v;
      sb.write_reg(REG_HEIGHT, data_v);
      @(posedge clock);
      data_v = 12'($urandom);
      csr_index <= REG_NONE;
      csr_data  <= data_v;
      sb.write_reg(REG_NONE, data_v);
      @(posedge clock);
      csr_write_en <= 1'b0;
      phase_count++;
   endtask

   // result side: random stalls plus one long hold-off
   initial begin : rsp_side
      int burst, hold;
      burst = 0;
      hold  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) sb.check_word(rsp_bus.word);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(99) < recv_idle_pct) begin
            burst = $urandom_range(1, 3) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int          random_sent, nitems, frames, pick, eff_w, eff_h, cur_eff_w;
      bit          fs_first, hold_issued, big_done;
      logic [1:0]  new_mode;
      logic [10:0] new_w;
      logic [11:0] new_h;
      logic [7:0]  pix;

      sb = new;
      sb.reset_state();
      quiet         = 1'b0;
      hold_request  = 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 20;
      pixels_sent   = 0;
      phase_count   = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.word  <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= REG_MODE;
      csr_data      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: first row only
      send_pixel(8'd0, 1'b1);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h5A, 1'b0);
      send_pixel(8'hA5, 1'b0);
      drain();

      // smallest frame with an interior pixel, clamped sum
      set_config(MODE_SUM, 11'd3, 12'd3);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            send_pixel((c == 0) ? 8'hFF : (c == 1) ? 8'd128 : 8'd0, (r == 0 && c == 0));
      drain();

      // negative x gradient
      set_config(MODE_X, 11'd3, 12'd3);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            send_pixel((c == 2) ? 8'hFF : 8'(r * 100), (r == 0 && c == 0));
      drain();

      // zero sizes act as one, position wraps every pixel
      set_config(MODE_COPY, 11'd0, 12'd0);
      send_pixel(8'd7, 1'b0);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'd0, 1'b0);
      drain();

      cur_eff_w   = 1;
      random_sent = 0;
      hold_issued = 1'b0;
      big_done    = 1'b0;
      while (random_sent < RANDOM_ITEMS) begin
         new_mode = 2'($urandom_range(0, 3));
         pick = $urandom_range(99);
         if (pick < 4) new_w = 11'd0;
         else if (pick == 4) new_w = 11'd1024;
         else if (pick == 5) new_w = 11'($urandom_range(1025, 2047));
         else if (pick < 75) new_w = 11'($urandom_range(1, 12));
         else new_w = 11'($urandom_range(13, 48));
         pick = $urandom_range(99);
         if (pick < 4) new_h = 12'd0;
         else if (pick < 70) new_h = 12'($urandom_range(1, 6));
         else new_h = 12'($urandom_range(7, 16));
         if (!big_done && random_sent >= 200) begin
            big_done = 1'b1;
            new_w = 11'd2047;
            new_h = 12'd4095;
         end
         eff_w = (new_w == 0) ? 1 : (new_w > LINE_DEPTH) ? LINE_DEPTH : new_w;
         eff_h = (new_h == 0) ? 1 : new_h;
         fs_first  = (eff_w > cur_eff_w) || ($urandom_range(3) != 0);
         cur_eff_w = eff_w;
         frames = $urandom_range(1, 3);
         nitems = frames * eff_w * eff_h;
         if ($urandom_range(3) == 0) nitems += $urandom_range(0, 2 * eff_w);
         if (new_w == 11'd2047 && new_h == 12'd4095) nitems = LINE_DEPTH + 8;
         else if (nitems > 300) nitems = $urandom_range(40, 300);
         if (nitems > RANDOM_ITEMS - random_sent) nitems = RANDOM_ITEMS - random_sent;
         case ($urandom_range(2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 15;
            default: send_idle_pct = 40;
         endcase
         case ($urandom_range(2))
            0: recv_idle_pct = 0;
            1: recv_idle_pct = 15;
            default: recv_idle_pct = 40;
         endcase
         quiet = (random_sent + nitems > RANDOM_ITEMS - 300);
         set_config(new_mode, new_w, new_h);
         if (!hold_issued && random_sent >= 400) begin
            hold_issued   = 1'b1;
            hold_request  = 1'b1;
            send_idle_pct = 0;
            if (nitems < 150) nitems = 150;
         end
         for (int i = 0; i < nitems; i++) begin
            pick = $urandom_range(9);
            pix  = (pick < 2) ? 8'd0 : (pick < 4) ? 8'hFF : 8'($urandom);
            send_pixel(pix, (i == 0 && fs_first) || ($urandom_range(249) == 0));
         end
         random_sent += nitems;
         drain();
      end

      quiet = 1'b1;
      drain();
      sb.flag_leftovers();
      $display("Ran %0d pixels over %0d register settings, %0d words checked.",
               pixels_sent, phase_count, sb.words_checked);
      $display("All modes, sizes from zero to oversized, clamped edges and a long output stall.");
      if (sb.mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
